/* src/sec_pkg.sv */
// ----------------------------------------------------------------------------
// sec_pkg
// Shared types, widths and helpers of the smallest enclosing circle block.
// ----------------------------------------------------------------------------
package sec_pkg;

  localparam int FRAC_BITS = 12;
  localparam int OUT_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int SLACK_W   = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FEW       = 2'd1,
    ST_COLLINEAR = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    C2_INIT  = 2'd0,
    C2_OUTER = 2'd1,
    C2_MID   = 2'd2
  } c2_kind_e;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

/* src/sec_if.sv */
// ----------------------------------------------------------------------------
// sec_in_if / sec_out_if
// Valid/ready channels for point items and circle result items.
// ----------------------------------------------------------------------------
interface sec_in_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface sec_out_if
  import sec_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_W-1:0]    center_x;
  logic signed [OUT_W-1:0]    center_y;
  logic        [OUT_W-1:0]    radius;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, center_x, center_y, radius, status, input ready);
  modport sink   (input valid, center_x, center_y, radius, status, output ready);
endinterface

/* src/sec_ram.sv */
// ----------------------------------------------------------------------------
// sec_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sec_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/smallest_enclosing_circle.sv */
// ----------------------------------------------------------------------------
// smallest_enclosing_circle
// Incremental three-level enclosing circle search over a point set held in RAM.
// Load one point item per cycle while in the load state; after the last point the
// search runs containment tests, two-point circles and three-point circles (19
// multiply steps, two divides, distance), then a square root and the emit.
// Worst case grows cubically with the point count; the next set waits for it.
// Reset clears control, count, flags and slack; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module smallest_enclosing_circle
  import sec_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sec_in_if.sink             in_i,
  sec_out_if.source          out_o,
  input  logic               slack_we_i,
  input  logic [SLACK_W-1:0] slack_wdata_i
);

  localparam int C  = COORD_BITS;
  localparam int PW = 2 * COORD_BITS;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [23:0] {
    S_LOAD     = 24'h000001,
    S_RD0      = 24'h000002,
    S_CAP0     = 24'h000004,
    S_CAP1     = 24'h000008,
    S_OUT_RD   = 24'h000010,
    S_OUT_CAP  = 24'h000020,
    S_OUT_CHK  = 24'h000040,
    S_MID_RD   = 24'h000080,
    S_MID_CAP  = 24'h000100,
    S_MID_CHK  = 24'h000200,
    S_IN_RD    = 24'h000400,
    S_IN_CAP   = 24'h000800,
    S_IN_CHK   = 24'h001000,
    S_C2       = 24'h002000,
    S_C2_DONE  = 24'h004000,
    S_DIST     = 24'h008000,
    S_C3_MUL   = 24'h010000,
    S_C3_CHK   = 24'h020000,
    S_DIV_INIT = 24'h040000,
    S_DIV_RUN  = 24'h080000,
    S_DIV_DONE = 24'h100000,
    S_C3_RAD   = 24'h200000,
    S_SQRT     = 24'h400000,
    S_EMIT     = 24'h800000
  } state_e;

  function automatic logic signed [32:0] ext33(input logic [C-1:0] v);
    return {{(33-C){v[C-1]}}, v};
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  state_e   state_q, state_d, ret_q, ret_d;
  c2_kind_e kind_q, kind_d;

  logic [CW-1:0]      cnt_q, cnt_d, o_q, o_d, m_q, m_d, i_q, i_d;
  logic [1:0]         flags_q, flags_d;
  logic [SLACK_W-1:0] slack_q, slack_d;

  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_cx_q, out_cx_d, out_cy_q, out_cy_d, out_r_q, out_r_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;

  logic [PW-1:0] p0_q, p0_d, po_q, po_d, pm_q, pm_d, pt_q, pt_d, dp_q, dp_d;
  logic [31:0]   cx_q, cx_d, cy_q, cy_d;
  logic [63:0]   rsq_q, rsq_d;

  logic [1:0]  dph_q, dph_d;
  logic [31:0] mx_q, mx_d, my_q, my_d;
  logic        bigx_q, bigx_d, bigy_q, bigy_d;
  logic [63:0] sq1_q, sq1_d, dist_q, dist_d;

  logic [5:0]  seq_q, seq_d;
  logic [63:0] acc_q, acc_d, bb_q, bb_d, dd_q, dd_d, det_q, det_d, nx_q, nx_d, ny_q, ny_d;

  logic        dsel_q, dsel_d, dneg_q, dneg_d, dovf_q, dovf_d;
  logic [76:0] divn_q, divn_d;
  logic [63:0] divd_q, divd_d;
  logic [64:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;

  logic [63:0] sqv_q, sqv_d, sqres_q, sqres_d, sqbit_q, sqbit_d;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] rd_data;

  logic [63:0] lim, px64, py64, dx, dy, adx, ady;
  logic        encl;

  logic signed [32:0] x1, y1, x2, y2, x3, y3, da, db, dc, de, bbl, bbh, ddl, ddh;

  assign lim  = sat_add64(rsq_q, {{(64-SLACK_W){1'b0}}, slack_q});
  assign encl = dist_q <= lim;

  assign px64 = {{(64-C){dp_q[C-1]}}, dp_q[C-1:0]};
  assign py64 = {{(64-C){dp_q[PW-1]}}, dp_q[PW-1:C]};
  assign dx   = {px64[63-FRAC_BITS:0], {FRAC_BITS{1'b0}}} - {{32{cx_q[31]}}, cx_q};
  assign dy   = {py64[63-FRAC_BITS:0], {FRAC_BITS{1'b0}}} - {{32{cy_q[31]}}, cy_q};
  assign adx  = abs64(dx);
  assign ady  = abs64(dy);

  assign x1  = ext33(po_q[C-1:0]);
  assign y1  = ext33(po_q[PW-1:C]);
  assign x2  = ext33(pm_q[C-1:0]);
  assign y2  = ext33(pm_q[PW-1:C]);
  assign x3  = ext33(pt_q[C-1:0]);
  assign y3  = ext33(pt_q[PW-1:C]);
  assign da  = x1 - x2;
  assign db  = y2 - y3;
  assign dc  = x2 - x3;
  assign de  = y1 - y2;
  assign bbl = {1'b0, bb_q[31:0]};
  assign bbh = {bb_q[63], bb_q[63:32]};
  assign ddl = {1'b0, dd_q[31:0]};
  assign ddh = {dd_q[63], dd_q[63:32]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_DIST) begin
      if (dph_q == 2'd1) begin
        mul_a = {1'b0, mx_q};
        mul_b = {1'b0, mx_q};
      end else if (dph_q == 2'd2) begin
        mul_a = {1'b0, my_q};
        mul_b = {1'b0, my_q};
      end
    end else if (state_q == S_C3_MUL) begin
      case (seq_q)
        6'd0:    begin mul_a = x1;  mul_b = x1; end
        6'd1:    begin mul_a = y1;  mul_b = y1; end
        6'd2:    begin mul_a = x2;  mul_b = x2; end
        6'd3:    begin mul_a = y2;  mul_b = y2; end
        6'd4:    begin mul_a = x2;  mul_b = x2; end
        6'd5:    begin mul_a = y2;  mul_b = y2; end
        6'd6:    begin mul_a = x3;  mul_b = x3; end
        6'd7:    begin mul_a = y3;  mul_b = y3; end
        6'd8:    begin mul_a = da;  mul_b = db; end
        6'd9:    begin mul_a = dc;  mul_b = de; end
        6'd10:   begin mul_a = bbl; mul_b = db; end
        6'd11:   begin mul_a = bbh; mul_b = db; end
        6'd12:   begin mul_a = ddl; mul_b = de; end
        6'd13:   begin mul_a = ddh; mul_b = de; end
        6'd14:   begin mul_a = ddl; mul_b = da; end
        6'd15:   begin mul_a = ddh; mul_b = da; end
        6'd16:   begin mul_a = bbl; mul_b = dc; end
        6'd17:   begin mul_a = bbh; mul_b = dc; end
        default: begin mul_a = '0;  mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_comb begin
    rd_addr = '0;
    case (state_q)
      S_RD0:    rd_addr = '0;
      S_CAP0:   rd_addr = AW'(1);
      S_OUT_RD: rd_addr = o_q[AW-1:0];
      S_MID_RD: rd_addr = m_q[AW-1:0];
      S_IN_RD:  rd_addr = i_q[AW-1:0];
      default:  rd_addr = '0;
    endcase
  end

  assign in_i.ready = (state_q == S_LOAD);
  assign wr_en      = in_i.valid && in_i.ready && (cnt_q < CW'(MAX_POINTS));

  sec_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({in_i.point_y, in_i.point_x}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    logic [63:0] term, num, den, nabs, dabs, t;
    logic [64:0] rsh;
    logic [44:0] csum;
    logic        ge, acc_clr, acc_sub, acc_hi;
    logic [32:0] sx, sy;

    state_d = state_q;  ret_d = ret_q;  kind_d = kind_q;
    cnt_d = cnt_q;  o_d = o_q;  m_d = m_q;  i_d = i_q;
    flags_d = flags_q;
    slack_d = slack_we_i ? slack_wdata_i : slack_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_cx_d = out_cx_q;  out_cy_d = out_cy_q;  out_r_d = out_r_q;  out_st_d = out_st_q;
    p0_d = p0_q;  po_d = po_q;  pm_d = pm_q;  pt_d = pt_q;  dp_d = dp_q;
    cx_d = cx_q;  cy_d = cy_q;  rsq_d = rsq_q;
    dph_d = dph_q;  mx_d = mx_q;  my_d = my_q;  bigx_d = bigx_q;  bigy_d = bigy_q;
    sq1_d = sq1_q;  dist_d = dist_q;
    seq_d = seq_q;
    acc_d = acc_q;  bb_d = bb_q;  dd_d = dd_q;  det_d = det_q;  nx_d = nx_q;  ny_d = ny_q;
    dsel_d = dsel_q;  dneg_d = dneg_q;  dovf_d = dovf_q;
    divn_d = divn_q;  divd_d = divd_q;  rem_d = rem_q;  quo_d = quo_q;
    sqv_d = sqv_q;  sqres_d = sqres_q;  sqbit_d = sqbit_q;

    term = '0;  num = '0;  den = '0;  nabs = '0;  dabs = '0;  t = '0;
    rsh = '0;  csum = '0;  ge = 1'b0;  sx = '0;  sy = '0;
    acc_clr = 1'b0;  acc_sub = 1'b0;  acc_hi = 1'b0;

    case (state_q)
      S_LOAD: begin
        if (in_i.valid) begin
          if (cnt_q < CW'(MAX_POINTS)) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            flags_d[1] = 1'b1;
          end
          if (in_i.last_point) begin
            state_d = S_RD0;
          end
        end
      end
      S_RD0: state_d = S_CAP0;
      S_CAP0: begin
        p0_d = rd_data;
        if (cnt_q < CW'(2)) begin
          csum  = {{12{rd_data[C-1]}}, ext33(rd_data[C-1:0])} <<< FRAC_BITS;
          cx_d  = csum[31:0];
          csum  = {{12{rd_data[PW-1]}}, ext33(rd_data[PW-1:C])} <<< FRAC_BITS;
          cy_d  = csum[31:0];
          rsq_d = '0;
          seq_d = '0;
          state_d = S_SQRT;
        end else begin
          state_d = S_CAP1;
        end
      end
      S_CAP1: begin
        po_d    = rd_data;
        kind_d  = C2_INIT;
        state_d = S_C2;
      end
      S_C2: begin
        if (kind_q == C2_MID) begin
          sx   = ext33(po_q[C-1:0]) + ext33(pm_q[C-1:0]);
          sy   = ext33(po_q[PW-1:C]) + ext33(pm_q[PW-1:C]);
          dp_d = po_q;
        end else begin
          sx   = ext33(p0_q[C-1:0]) + ext33(po_q[C-1:0]);
          sy   = ext33(p0_q[PW-1:C]) + ext33(po_q[PW-1:C]);
          dp_d = p0_q;
        end
        csum    = {{12{sx[32]}}, sx} <<< (FRAC_BITS - 1);
        cx_d    = csum[31:0];
        csum    = {{12{sy[32]}}, sy} <<< (FRAC_BITS - 1);
        cy_d    = csum[31:0];
        dph_d   = '0;
        ret_d   = S_C2_DONE;
        state_d = S_DIST;
      end
      S_C2_DONE: begin
        rsq_d = dist_q;
        case (kind_q)
          C2_INIT: begin
            o_d = CW'(2);
            state_d = S_OUT_RD;
          end
          C2_OUTER: begin
            m_d = CW'(1);
            state_d = S_MID_RD;
          end
          default: begin
            i_d = '0;
            state_d = S_IN_RD;
          end
        endcase
      end
      S_OUT_RD: begin
        if (o_q == cnt_q) begin
          seq_d   = '0;
          state_d = S_SQRT;
        end else begin
          state_d = S_OUT_CAP;
        end
      end
      S_OUT_CAP: begin
        po_d = rd_data;  dp_d = rd_data;  dph_d = '0;
        ret_d = S_OUT_CHK;  state_d = S_DIST;
      end
      S_OUT_CHK: begin
        if (encl) begin
          o_d = o_q + CW'(1);
          state_d = S_OUT_RD;
        end else begin
          kind_d = C2_OUTER;
          state_d = S_C2;
        end
      end
      S_MID_RD: begin
        if (m_q == o_q) begin
          o_d = o_q + CW'(1);
          state_d = S_OUT_RD;
        end else begin
          state_d = S_MID_CAP;
        end
      end
      S_MID_CAP: begin
        pm_d = rd_data;  dp_d = rd_data;  dph_d = '0;
        ret_d = S_MID_CHK;  state_d = S_DIST;
      end
      S_MID_CHK: begin
        if (encl) begin
          m_d = m_q + CW'(1);
          state_d = S_MID_RD;
        end else begin
          kind_d = C2_MID;
          state_d = S_C2;
        end
      end
      S_IN_RD: begin
        if (i_q == m_q) begin
          m_d = m_q + CW'(1);
          state_d = S_MID_RD;
        end else begin
          state_d = S_IN_CAP;
        end
      end
      S_IN_CAP: begin
        pt_d = rd_data;  dp_d = rd_data;  dph_d = '0;
        ret_d = S_IN_CHK;  state_d = S_DIST;
      end
      S_IN_CHK: begin
        if (encl) begin
          i_d = i_q + CW'(1);
          state_d = S_IN_RD;
        end else begin
          seq_d = '0;
          state_d = S_C3_MUL;
        end
      end
      S_DIST: begin
        dph_d = dph_q + 2'd1;
        case (dph_q)
          2'd0: begin
            mx_d = adx[31:0];  bigx_d = |adx[63:32];
            my_d = ady[31:0];  bigy_d = |ady[63:32];
          end
          2'd1: ;
          2'd2: sq1_d = bigx_q ? '1 : prod_q[63:0];
          default: begin
            dist_d  = sat_add64(sq1_q, bigy_q ? '1 : prod_q[63:0]);
            state_d = ret_q;
          end
        endcase
      end
      S_C3_MUL: begin
        seq_d = seq_q + 6'd1;
        if (seq_q != '0) begin
          acc_clr = seq_q inside {6'd1, 6'd5, 6'd9, 6'd11, 6'd15};
          acc_sub = seq_q inside {6'd3, 6'd4, 6'd7, 6'd8, 6'd10, 6'd13, 6'd14, 6'd17, 6'd18};
          acc_hi  = seq_q inside {6'd12, 6'd14, 6'd16, 6'd18};
          term    = acc_hi ? {prod_q[31:0], 32'd0} : prod_q[63:0];
          acc_d   = acc_clr ? '0 : acc_q;
          acc_d   = acc_sub ? (acc_d - term) : (acc_d + term);
          case (seq_q)
            6'd4:    bb_d  = acc_d;
            6'd8:    dd_d  = acc_d;
            6'd10:   det_d = acc_d;
            6'd14:   nx_d  = acc_d;
            6'd18: begin
              ny_d    = acc_d;
              state_d = S_C3_CHK;
            end
            default: ;
          endcase
        end
      end
      S_C3_CHK: begin
        if (det_q == '0) begin
          flags_d[0] = 1'b1;
          i_d = i_q + CW'(1);
          state_d = S_IN_RD;
        end else begin
          dsel_d  = 1'b0;
          state_d = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        num     = dsel_q ? ny_q : nx_q;
        den     = {det_q[62:0], 1'b0};
        nabs    = abs64(num);
        dabs    = abs64(den);
        dneg_d  = num[63] ^ den[63];
        divn_d  = {1'b0, nabs, {FRAC_BITS{1'b0}}} + {14'd0, dabs[63:1]};
        divd_d  = dabs;
        seq_d   = '0;
        state_d = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (seq_q == '0) begin
          dovf_d = {19'd0, divn_q[76:32]} >= divd_q;
          rem_d  = {20'd0, divn_q[76:32]};
          seq_d  = 6'd1;
        end else begin
          rsh    = {rem_q[63:0], divn_q[31]};
          ge     = rsh >= {1'b0, divd_q};
          rem_d  = ge ? (rsh - {1'b0, divd_q}) : rsh;
          quo_d  = {quo_q[30:0], ge};
          divn_d = {divn_q[75:0], 1'b0};
          if (seq_q == 6'd32) begin
            state_d = S_DIV_DONE;
          end else begin
            seq_d = seq_q + 6'd1;
          end
        end
      end
      S_DIV_DONE: begin
        if (dneg_q) begin
          if (dovf_q || (quo_q > 32'h8000_0000)) begin
            t[31:0] = 32'h8000_0000;
            flags_d[1] = 1'b1;
          end else begin
            t[31:0] = 32'd0 - quo_q;
          end
        end else begin
          if (dovf_q || quo_q[31]) begin
            t[31:0] = 32'h7fff_ffff;
            flags_d[1] = 1'b1;
          end else begin
            t[31:0] = quo_q;
          end
        end
        if (!dsel_q) begin
          cx_d    = t[31:0];
          dsel_d  = 1'b1;
          state_d = S_DIV_INIT;
        end else begin
          cy_d    = t[31:0];
          dp_d    = pm_q;
          dph_d   = '0;
          ret_d   = S_C3_RAD;
          state_d = S_DIST;
        end
      end
      S_C3_RAD: begin
        rsq_d = dist_q;
        if (&dist_q) begin
          flags_d[1] = 1'b1;
        end
        i_d = i_q + CW'(1);
        state_d = S_IN_RD;
      end
      S_SQRT: begin
        if (seq_q == '0) begin
          sqv_d   = rsq_q;
          sqres_d = '0;
          sqbit_d = 64'h4000_0000_0000_0000;
          seq_d   = 6'd1;
        end else begin
          t = sqres_q + sqbit_q;
          if (sqv_q >= t) begin
            sqv_d   = sqv_q - t;
            sqres_d = (sqres_q >> 1) + sqbit_q;
          end else begin
            sqres_d = sqres_q >> 1;
          end
          sqbit_d = sqbit_q >> 2;
          if (seq_q == 6'd32) begin
            state_d = S_EMIT;
          end else begin
            seq_d = seq_q + 6'd1;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_cx_d    = cx_q;
          out_cy_d    = cy_q;
          out_r_d     = sqres_q[31:0];
          if (cnt_q < CW'(2)) begin
            out_st_d = ST_FEW;
          end else if (flags_q[1]) begin
            out_st_d = ST_OVERFLOW;
          end else if (flags_q[0]) begin
            out_st_d = ST_COLLINEAR;
          end else begin
            out_st_d = ST_OK;
          end
          cnt_d   = '0;
          flags_d = '0;
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      ret_q       <= S_LOAD;
      kind_q      <= C2_INIT;
      cnt_q       <= '0;
      o_q         <= '0;
      m_q         <= '0;
      i_q         <= '0;
      flags_q     <= '0;
      slack_q     <= '0;
      out_valid_q <= 1'b0;
      dph_q       <= '0;
      seq_q       <= '0;
      dsel_q      <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      rsq_q       <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      o_q         <= o_d;
      m_q         <= m_d;
      i_q         <= i_d;
      flags_q     <= flags_d;
      slack_q     <= slack_d;
      out_valid_q <= out_valid_d;
      dph_q       <= dph_d;
      seq_q       <= seq_d;
      dsel_q      <= dsel_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      rsq_q       <= rsq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cx_q <= out_cx_d;  out_cy_q <= out_cy_d;  out_r_q <= out_r_d;  out_st_q <= out_st_d;
    p0_q <= p0_d;  po_q <= po_d;  pm_q <= pm_d;  pt_q <= pt_d;  dp_q <= dp_d;
    mx_q <= mx_d;  my_q <= my_d;  bigx_q <= bigx_d;  bigy_q <= bigy_d;
    sq1_q <= sq1_d;  dist_q <= dist_d;
    acc_q <= acc_d;  bb_q <= bb_d;  dd_q <= dd_d;  det_q <= det_d;  nx_q <= nx_d;  ny_q <= ny_d;
    dneg_q <= dneg_d;  dovf_q <= dovf_d;
    divn_q <= divn_d;  divd_q <= divd_d;  rem_q <= rem_d;  quo_q <= quo_d;
    sqv_q <= sqv_d;  sqres_q <= sqres_d;  sqbit_q <= sqbit_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.center_x = out_cx_q;
  assign out_o.center_y = out_cy_q;
  assign out_o.radius   = out_r_q;
  assign out_o.status   = out_st_q;

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  ap_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_RUN) |-> (divd_q != '0))
    else $error("divider running with zero divisor");

  ap_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IN_CHK) |-> ((i_q < m_q) && (m_q < o_q) && (o_q < cnt_q)))
    else $error("loop indices out of order");

endmodule

/* tb/sv/smallest_enclosing_circle_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smallest_enclosing_circle_test
// Loads point sets into the enclosing circle block through its valid/ready
// channel and checks every circle it returns against a predictor that redoes
// the three-level search in exact integer arithmetic. The tolerance register
// is changed between phases. Both sides insert random idle cycles outside the quiet
// last phase, and there is one long result stall while the sender keeps offering points.
// ----------------------------------------------------------------------------
module smallest_enclosing_circle_test;
  import sec_pkg::*;

  localparam int NPTS     = 1024;
  localparam int CBITS    = 20;
  localparam int PERIOD   = 12;
  localparam int SETTLE   = 200;

  typedef struct {
    logic signed [CBITS-1:0] x;
    logic signed [CBITS-1:0] y;
    logic                    last;
  } point_t;

  typedef struct {
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic [OUT_W-1:0]        r;
    status_e                 st;
  } circle_t;

  localparam bit [1:0] FL_COLLINEAR = 2'b01;
  localparam bit [1:0] FL_OVERFLOW  = 2'b10;

  logic clk_i;
  logic rst_ni;
  logic slack_we_i;
  logic [SLACK_W-1:0] slack_wdata_i;

  sec_in_if #(.COORD_BITS(CBITS)) in_if ();
  sec_out_if out_if ();

  smallest_enclosing_circle #(.MAX_POINTS(NPTS), .COORD_BITS(CBITS)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_o        (out_if),
    .slack_we_i   (slack_we_i),
    .slack_wdata_i(slack_wdata_i)
  );

  point_t  point_q[$];
  circle_t circle_q[$];
  bit      mismatch_seen = 0;
  bit      quiet = 0;
  bit      hold_start = 0;
  int      in_accepts = 0;

  // predictor state
  longint     sx[NPTS];
  longint     sy[NPTS];
  int         n_stored = 0;
  longint     ccx = 0;
  longint     ccy = 0;
  bit [63:0]  crsq = 0;
  bit [1:0]   flags = 0;
  bit [15:0]  slack = 0;

  function automatic bit [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] sadd(bit [63:0] a, bit [63:0] b);
    bit [63:0] s;
    s = a + b;
    return s < a ? '1 : s;
  endfunction

  function automatic bit [63:0] sq_mag(longint d);
    bit [63:0] m;
    m = mag(d);
    if (m >= 64'h1_0000_0000) return '1;
    return m * m;
  endfunction

  function automatic bit [63:0] dist_sq(int i, longint cx, longint cy);
    return sadd(sq_mag(sx[i] * 4096 - cx), sq_mag(sy[i] * 4096 - cy));
  endfunction

  function automatic bit covers(int i);
    return dist_sq(i, ccx, ccy) <= sadd(crsq, {48'd0, slack});
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      flags |= FL_OVERFLOW;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flags |= FL_OVERFLOW;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint div_q12(longint num, longint den);
    bit [63:0] n, d, q, r, fr;
    bit        neg;
    longint    v;
    n = mag(num);
    d = mag(den);
    neg = (num < 0) != (den < 0);
    q = n / d;
    r = n % d;
    fr = (r * 4096 + d / 2) / d;
    if (q > 64'd1048576) q = 64'd1048576;
    v = longint'(q * 4096 + fr);
    return clamp32(neg ? -v : v);
  endfunction

  function automatic void diameter_circle(int a, int b);
    ccx = (sx[a] + sx[b]) * 2048;
    ccy = (sy[a] + sy[b]) * 2048;
    crsq = dist_sq(a, ccx, ccy);
  endfunction

  function automatic void circumcircle(int a, int b, int c);
    longint s2, bb, dd, det, nx, ny;
    bit [63:0] rs;
    s2 = sx[b] * sx[b] + sy[b] * sy[b];
    bb = sx[a] * sx[a] + sy[a] * sy[a] - s2;
    dd = s2 - sx[c] * sx[c] - sy[c] * sy[c];
    det = (sx[a] - sx[b]) * (sy[b] - sy[c]) - (sx[b] - sx[c]) * (sy[a] - sy[b]);
    if (det == 0) begin
      flags |= FL_COLLINEAR;
      return;
    end
    nx = bb * (sy[b] - sy[c]) - dd * (sy[a] - sy[b]);
    ny = dd * (sx[a] - sx[b]) - bb * (sx[b] - sx[c]);
    ccx = div_q12(nx, det * 2);
    ccy = div_q12(ny, det * 2);
    rs = dist_sq(b, ccx, ccy);
    if (rs == '1) flags |= FL_OVERFLOW;
    crsq = rs;
  endfunction

  function automatic bit [63:0] isqrt(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void predict_circle(point_t p);
    circle_t e;
    if (n_stored < NPTS) begin
      sx[n_stored] = longint'(p.x);
      sy[n_stored] = longint'(p.y);
      n_stored++;
    end else begin
      flags |= FL_OVERFLOW;
    end
    if (!p.last) return;
    if (n_stored < 2) begin
      ccx = sx[0] * 4096;
      ccy = sy[0] * 4096;
      crsq = 0;
    end else begin
      diameter_circle(0, 1);
      for (int o = 2; o < n_stored; o++) begin
        if (covers(o)) continue;
        diameter_circle(0, o);
        for (int m = 1; m < o; m++) begin
          if (covers(m)) continue;
          diameter_circle(o, m);
          for (int k = 0; k < m; k++)
            if (!covers(k)) circumcircle(o, m, k);
        end
      end
    end
    if (n_stored < 2) e.st = ST_FEW;
    else if (flags & FL_OVERFLOW) e.st = ST_OVERFLOW;
    else if (flags & FL_COLLINEAR) e.st = ST_COLLINEAR;
    else e.st = ST_OK;
    e.cx = ccx[31:0];
    e.cy = ccy[31:0];
    e.r = 32'(isqrt(crsq));
    circle_q = {circle_q, e};
    n_stored = 0;
    flags = 0;
  endfunction

  initial begin
    clk_i = 0;
    forever #(PERIOD / 2) clk_i = ~clk_i;
  end

  // accept points, predict, and check returned circles
  always @(posedge clk_i) begin
    circle_t e;
    point_t  p;
    if (rst_ni) begin
      if (slack_we_i) slack = slack_wdata_i;
      if (in_if.valid && in_if.ready) begin
        p.x = in_if.point_x;
        p.y = in_if.point_y;
        p.last = in_if.last_point;
        predict_circle(p);
        in_accepts++;
      end
      if (out_if.valid && out_if.ready) begin
        if (circle_q.size() == 0) begin
          $error("unexpected circle cx=%0d cy=%0d r=%0d", out_if.center_x,
                 out_if.center_y, out_if.radius);
          mismatch_seen = 1;
        end else begin
          e = circle_q.pop_front();
          if (out_if.center_x !== e.cx) begin
            $error("center_x expected %0d actual %0d", e.cx, out_if.center_x);
            mismatch_seen = 1;
          end
          if (out_if.center_y !== e.cy) begin
            $error("center_y expected %0d actual %0d", e.cy, out_if.center_y);
            mismatch_seen = 1;
          end
          if (out_if.radius !== e.r) begin
            $error("radius expected %0d actual %0d", e.r, out_if.radius);
            mismatch_seen = 1;
          end
          if (out_if.status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, out_if.status);
            mismatch_seen = 1;
          end
        end
      end
    end
  end

  // point driver
  int sent = 0;
  int tx_gap = 0;
  always @(negedge clk_i) begin
    point_t p;
    logic   v;
    if (rst_ni) begin
      v = in_if.valid;
      if (!in_if.valid || in_accepts == sent) begin
        v = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 2);
        end else if (point_q.size() != 0) begin
          p = point_q.pop_front();
          v = 1'b1;
          sent++;
          in_if.point_x <= p.x;
          in_if.point_y <= p.y;
          in_if.last_point <= p.last;
        end
      end
      in_if.valid <= v;
    end
  end

  // result receiver
  int  rx_gap = 0;
  bit  hold_taken = 0;
  always @(negedge clk_i) begin
    logic r;
    r = 1'b1;
    if (rst_ni) begin
      if (hold_start && !hold_taken) begin
        hold_taken = 1;
        rx_gap = 3000;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        r = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 2);
        r = 1'b0;
      end
    end
    out_if.ready <= r;
  end

  task automatic add_point(int x, int y, bit last);
    point_t p;
    p.x = x[CBITS-1:0];
    p.y = y[CBITS-1:0];
    p.last = last;
    point_q = {point_q, p};
  endtask

  task automatic add_set(int n, int span);
    int x, y;
    for (int i = 0; i < n; i++) begin
      if (span == 0) begin
        x = int'($signed($urandom() & 32'hFFFFF) <<< 12) >>> 12;
        y = int'($signed($urandom() & 32'hFFFFF) <<< 12) >>> 12;
      end else begin
        x = int'($urandom_range(0, 2 * span)) - span;
        y = int'($urandom_range(0, 2 * span)) - span;
      end
      add_point(x, y, i == n - 1);
    end
  endtask

  task automatic add_random_sets(int items);
    int spans[4] = '{2, 60, 5000, 0};
    int n, k;
    k = 0;
    while (k < items) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 9);
      add_set(n, spans[$urandom_range(0, 3)]);
      k += n;
    end
  endtask

  task automatic drain();
    while (point_q.size() != 0 || in_if.valid || circle_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_slack(bit [15:0] v);
    @(negedge clk_i);
    slack_we_i <= 1'b1;
    slack_wdata_i <= v;
    @(negedge clk_i);
    slack_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni = 0;
    slack_we_i = 0;
    slack_wdata_i = 0;
    in_if.valid = 0;
    in_if.point_x = 0;
    in_if.point_y = 0;
    in_if.last_point = 0;
    out_if.ready = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    add_point(-524288, 524287, 1);
    add_point(524287, -524288, 0);
    add_point(-524288, 524287, 1);
    add_point(-524288, -524288, 0);
    add_point(524287, 524287, 0);
    add_point(524287, -524288, 0);
    add_point(-524288, 524287, 1);
    add_point(0, 0, 0);
    add_point(4, 0, 0);
    add_point(2, 3, 1);
    add_point(0, 0, 0);
    add_point(1, 1, 0);
    add_point(3, 3, 0);
    add_point(2, 2, 0);
    add_point(-1, -1, 1);
    add_point(-524288, 0, 0);
    add_point(524287, 1, 0);
    add_point(0, 524287, 1);
    add_point(-7, -1, 0);
    add_point(9, 1, 1);
    drain();

    write_slack(16'hFFFF);
    add_random_sets(300);
    drain();

    write_slack(16'($urandom_range(1, 65534)));
    hold_start = 1;
    add_random_sets(250);
    drain();

    write_slack(16'd0);
    add_random_sets(250);
    drain();

    write_slack(16'd1);
    quiet = 1;
    add_random_sets(220);
    drain();

    if (!mismatch_seen) begin
      $display("smallest_enclosing_circle_test passed");
    end else begin
      $display("smallest_enclosing_circle_test failed");
    end
    $finish;
  end

  initial begin
    #(64'd200_000_000);
    $display("smallest_enclosing_circle_test failed");
    $finish;
  end

endmodule
